FILE: design/tbsc_pkg.sv
package tbsc_pkg;

    // field widths
    localparam int RE_W   = 16;
    localparam int RATE_W = 10;
    localparam int MOD_W  = 4;
    localparam int LAY_W  = 4;
    localparam int TBS_W  = 23;

    // internal widths
    localparam int RR_W  = RE_W + RATE_W;   // re_count * rate
    localparam int ML_W  = MOD_W + LAY_W;   // modulation * layers
    localparam int P_W   = RR_W + ML_W;     // full product, q.10
    localparam int TB_W  = 6;               // bit index into P_W
    localparam int SM_W  = 22;              // small branch value width
    localparam int VAL_W = 25;              // quantized info bits
    localparam int RND_W = VAL_W + 1;       // after byte round-up

    localparam int FRAC_BITS = 10;

    localparam logic [P_W-1:0]    SMALL_LIMIT_Q = P_W'(3824) << FRAC_BITS;
    localparam logic [P_W-1:0]    OFFSET_Q      = P_W'(24) << FRAC_BITS;
    localparam logic [RATE_W-1:0] BG2_RATE_MAX  = RATE_W'(256);
    localparam logic [VAL_W-1:0]  BG1_SIZE_MAX  = VAL_W'(8424);
    localparam logic [VAL_W-1:0]  OFFSET_BITS   = VAL_W'(24);
    localparam logic [RND_W-1:0]  MIN_BLOCK     = RND_W'(24);
    localparam logic [RND_W-1:0]  OUT_MAX       = RND_W'(23'h7FFFFF);
    localparam logic [TBS_W-1:0]  OUT_SAT       = TBS_W'(8388600);

    // index of the highest set bit, 0 for zero
    function automatic logic [TB_W-1:0] top_bit(input logic [P_W-1:0] x);
        logic [TB_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < P_W; i++) begin
            if (x[i]) begin
                idx = TB_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: design/tbsc_req_if.sv
interface tbsc_req_if;
    import tbsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [RE_W-1:0]   re_count;
    logic [RATE_W-1:0] rate_x1024;
    logic [MOD_W-1:0]  bits_per_symbol;
    logic [LAY_W-1:0]  layer_count;

    modport source (
        output valid, re_count, rate_x1024, bits_per_symbol, layer_count,
        input  ready
    );
    modport sink (
        input  valid, re_count, rate_x1024, bits_per_symbol, layer_count,
        output ready
    );
endinterface

FILE: design/tbsc_rsp_if.sv
interface tbsc_rsp_if;
    import tbsc_pkg::*;

    logic             valid;
    logic             ready;
    logic [TBS_W-1:0] block_size_bits;

    modport source (
        output valid, block_size_bits,
        input  ready
    );
    modport sink (
        input  valid, block_size_bits,
        output ready
    );
endinterface

FILE: design/transport_block_size_calc.sv
// five register stages; each result is held in the stage 5 output register until it is taken
// throughput: one request per cycle while results are taken, no bubbles between back-to-back requests
// a stalled result freezes all five stages together; nothing is dropped or repeated
// reset (synchronous, active low) clears the stage valid bits only
// payload registers are not reset
module transport_block_size_calc (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbsc_req_if.sink   i_req,
    tbsc_rsp_if.source o_rsp
);
    import tbsc_pkg::*;

    // whole pipe moves when the output register is empty or being drained
    logic adv;
    assign adv         = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = adv;

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // side flags that ride with each request: any field zero, low code rate
    logic r_z1, r_z2, r_z3, r_z4;
    logic r_lo1, r_lo2, r_lo3, r_lo4;

    // stage 1: the two partial products
    logic [RR_W-1:0] r_rr1;
    logic [ML_W-1:0] r_ml1;

    // stage 2: full product in q.10
    logic [P_W-1:0] r_p2;

    // stage 3: branch select, operand and its top bit
    logic            r_small3;
    logic [P_W-1:0]  r_x3;
    logic [TB_W-1:0] r_tb3;

    // stage 4: quantized info bits
    logic             r_small4;
    logic [VAL_W-1:0] r_val4;

    // stage 5: output register
    logic [TBS_W-1:0] r_out5;

    // ---------------- stage 3 logic ----------------
    logic           n_small3;
    logic [P_W-1:0] n_x3;

    always_comb begin
        n_small3 = (r_p2 <= SMALL_LIMIT_Q);
        // large branch works on n_info - 24
        n_x3     = n_small3 ? r_p2 : (r_p2 - OFFSET_Q);
    end

    // ---------------- stage 4 logic ----------------
    // small branch: n = log2 floor, s = n - 3, keep top bits, drop offset
    logic [TB_W-1:0]  sm_n;
    logic [TB_W-1:0]  sm_s;
    logic [SM_W-1:0]  sm_q;
    logic [SM_W-1:0]  sm_np;
    logic [VAL_W-1:0] sm_val;
    // large branch: round to nearest at a power-of-two step
    logic [TB_W-1:0]  lg_n;
    logic [P_W:0]     lg_sum;
    logic [VAL_W-1:0] lg_mask;
    logic [VAL_W-1:0] lg_val;
    logic [VAL_W-1:0] n_val4;

    always_comb begin
        sm_n   = (r_tb3 > TB_W'(FRAC_BITS)) ? (r_tb3 - TB_W'(FRAC_BITS)) : '0;
        sm_s   = (sm_n > TB_W'(2)) ? (sm_n - TB_W'(3)) : '0;
        sm_q   = SM_W'(r_x3 >> (TB_W'(FRAC_BITS) + sm_s));
        sm_np  = (sm_q > SM_W'(OFFSET_BITS + VAL_W'(1))) ?
                 (sm_q - SM_W'(OFFSET_BITS)) : SM_W'(1);
        sm_val = VAL_W'(sm_np) << sm_s;

        lg_n    = (r_tb3 > TB_W'(FRAC_BITS + 5)) ?
                  (r_tb3 - TB_W'(FRAC_BITS + 5)) : '0;
        // half of the step, then drop fraction and the low n bits
        lg_sum  = {1'b0, r_x3} + ((P_W+1)'(1) << (TB_W'(FRAC_BITS - 1) + lg_n));
        lg_mask = ~((VAL_W'(1) << lg_n) - VAL_W'(1));
        lg_val  = VAL_W'(lg_sum >> FRAC_BITS) & lg_mask;

        n_val4 = r_small3 ? sm_val : lg_val;
    end

    // ---------------- stage 5 logic ----------------
    logic [VAL_W-1:0] fin_pre;
    logic [RND_W-1:0] fin_rnd;
    logic [TBS_W-1:0] n_out5;

    always_comb begin
        // base graph 1 above the size limit loses the crc bits
        fin_pre = (!r_small4 && !r_lo4 && (r_val4 > BG1_SIZE_MAX)) ?
                  (r_val4 - OFFSET_BITS) : r_val4;
        fin_rnd = (RND_W'(fin_pre) + RND_W'(7)) & ~RND_W'(7);
        if (fin_rnd < MIN_BLOCK) begin
            fin_rnd = MIN_BLOCK;
        end
        if (r_z4) begin
            n_out5 = '0;
        end else if (fin_rnd > OUT_MAX) begin
            n_out5 = OUT_SAT;
        end else begin
            n_out5 = TBS_W'(fin_rnd);
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // stage 1
            r_rr1 <= RR_W'(i_req.re_count) * RR_W'(i_req.rate_x1024);
            r_ml1 <= ML_W'(i_req.bits_per_symbol) * ML_W'(i_req.layer_count);
            r_z1  <= (i_req.re_count == '0) || (i_req.rate_x1024 == '0) ||
                     (i_req.bits_per_symbol == '0) || (i_req.layer_count == '0);
            r_lo1 <= (i_req.rate_x1024 <= BG2_RATE_MAX);
            // stage 2
            r_p2  <= P_W'(r_rr1) * P_W'(r_ml1);
            r_z2  <= r_z1;
            r_lo2 <= r_lo1;
            // stage 3
            r_small3 <= n_small3;
            r_x3     <= n_x3;
            r_tb3    <= top_bit(n_x3);
            r_z3     <= r_z2;
            r_lo3    <= r_lo2;
            // stage 4
            r_small4 <= r_small3;
            r_val4   <= n_val4;
            r_z4     <= r_z3;
            r_lo4    <= r_lo3;
            // stage 5
            r_out5   <= n_out5;
        end
    end

    assign o_rsp.valid           = r_v5;
    assign o_rsp.block_size_bits = r_out5;

    // ---------------- checks ----------------
    // a valid nonzero size is always whole bytes and at least the minimum
    a_out_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.block_size_bits != '0)) |->
        ((o_rsp.block_size_bits[2:0] == 3'b000) &&
         (o_rsp.block_size_bits >= TBS_W'(MIN_BLOCK))))
        else $error("result not byte aligned or below minimum");

    // a request with a zero layer count is flagged in stage 1
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.layer_count == '0)) |=>
        (r_v1 && r_z1))
        else $error("zero field not flagged");

    // a held output freezes the stage valid bits
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=>
        ($stable({r_v1, r_v2, r_v3, r_v4}) && r_v5))
        else $error("pipeline moved during stall");

    // small branch operand never exceeds its limit
    a_small_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_small3) |-> (r_x3 <= SMALL_LIMIT_Q))
        else $error("small branch operand out of range");

endmodule

FILE: bench/tbsc_checker.sv
`timescale 1ns / 100ps

module tbsc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tbsc_req_if  i_req,
    tbsc_rsp_if  i_rsp,
    output int   o_pending,
    output int   o_fail_count
);
    import tbsc_pkg::*;

    localparam logic [63:0] SMALL_MAX_Q   = 64'd3824 << FRAC_BITS;
    localparam logic [63:0] INFO_OFFSET   = 64'd24;
    localparam logic [63:0] LOW_RATE_MAX  = 64'd256;
    localparam logic [63:0] BG1_INFO_MAX  = 64'd8424;
    localparam logic [63:0] SIZE_FLOOR    = 64'd24;
    localparam logic [63:0] SIZE_CEIL     = 64'h7FFFFF;
    localparam logic [63:0] SIZE_SATURATE = 64'd8388600;

    logic [TBS_W-1:0] size_queue[$];

    function automatic int unsigned msb_index(input logic [63:0] x);
        int unsigned idx;
        idx = 0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                idx = i;
            end
        end
        return idx;
    endfunction

    function automatic logic [63:0] round_up_bytes(input logic [63:0] x);
        return (x + 64'd7) & ~64'd7;
    endfunction

    function automatic logic [TBS_W-1:0] predict_block_size(
        input logic [RE_W-1:0]   re,
        input logic [RATE_W-1:0] rate,
        input logic [MOD_W-1:0]  bps,
        input logic [LAY_W-1:0]  layers
    );
        logic [63:0] prod, quot, trimmed, excess, rounded, quant, size;
        int unsigned top, lg, step, shift;
        if (re == '0 || rate == '0 || bps == '0 || layers == '0) begin
            return '0;
        end
        // n_info in q.10, exact
        prod = 64'(re) * 64'(rate) * 64'(bps) * 64'(layers);
        if (prod <= SMALL_MAX_Q) begin
            top     = msb_index(prod);
            lg      = (top > FRAC_BITS) ? top - FRAC_BITS : 0;
            step    = (lg > 2) ? lg - 3 : 0;
            quot    = prod >> (FRAC_BITS + step);
            trimmed = (quot > INFO_OFFSET + 1) ? quot - INFO_OFFSET : 64'd1;
            size    = round_up_bytes(trimmed << step);
        end else begin
            excess  = prod - (INFO_OFFSET << FRAC_BITS);
            top     = msb_index(excess);
            lg      = (top > FRAC_BITS + 5) ? top - FRAC_BITS - 5 : 0;
            shift   = FRAC_BITS + lg;
            rounded = (excess + (64'd1 << (shift - 1))) >> shift;
            quant   = rounded << lg;
            if (64'(rate) <= LOW_RATE_MAX) begin
                size = round_up_bytes(quant);
            end else if (quant > BG1_INFO_MAX) begin
                size = round_up_bytes(quant - INFO_OFFSET);
            end else begin
                size = round_up_bytes(quant);
            end
        end
        if (size < SIZE_FLOOR) begin
            size = SIZE_FLOOR;
        end
        if (size > SIZE_CEIL) begin
            size = SIZE_SATURATE;
        end
        return size[TBS_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [TBS_W-1:0] want;
        if (!i_rst_n) begin
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                size_queue.push_back(predict_block_size(i_req.re_count, i_req.rate_x1024,
                    i_req.bits_per_symbol, i_req.layer_count));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (size_queue.size() == 0) begin
                    $error("block_size_bits: result with no request outstanding, actual %0d",
                        i_rsp.block_size_bits);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = size_queue.pop_front();
                    if (i_rsp.block_size_bits !== want) begin
                        $error("block_size_bits mismatch: expected %0d, actual %0d",
                            want, i_rsp.block_size_bits);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= size_queue.size();
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import tbsc_pkg::*;

    // stimulus sizing
    localparam int RANDOM_REQUESTS = 1530;
    // request counts bounding the stretch with no idling on either side
    localparam int QUIET_FROM      = 400;
    localparam int QUIET_TO        = 800;
    // long receiver hold-off, placed inside the quiet stretch
    localparam int STALL_AT        = 500;
    localparam int STALL_CYCLES    = 60;
    // watchdog: cycles without any handshake before giving up
    localparam int HANG_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 10;

    logic i_clk;
    logic i_rst_n;

    tbsc_req_if req_ch();
    tbsc_rsp_if rsp_ch();

    int pending;
    int fail_count;
    int sent;
    int idle_cycles;
    bit idle_on;
    bit stall_done;

    transport_block_size_calc dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    tbsc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one request, with random idle cycles ahead of it outside the quiet stretch, and wait for accept
    // valid stays high afterwards so back-to-back requests need no second write
    task automatic send_request(
        input logic [RE_W-1:0]   re,
        input logic [RATE_W-1:0] rate,
        input logic [MOD_W-1:0]  bps,
        input logic [LAY_W-1:0]  layers
    );
        while (idle_on && $urandom_range(0, 99) < 25) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.re_count        <= re;
        req_ch.rate_x1024      <= rate;
        req_ch.bits_per_symbol <= bps;
        req_ch.layer_count     <= layers;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        sent++;
        idle_on = !(sent >= QUIET_FROM && sent < QUIET_TO);
    endtask

    // random allocation, mostly valid, some small ones for the small branch,
    // some out-of-range modulation or layers and a few invalid zero fields
    task automatic send_random_request();
        logic [RE_W-1:0]   re;
        logic [RATE_W-1:0] rate;
        logic [MOD_W-1:0]  bps;
        logic [LAY_W-1:0]  layers;
        if ($urandom_range(0, 99) < 30) begin
            re = RE_W'($urandom_range(1, 300));
        end else begin
            re = RE_W'($urandom_range(1, 65535));
        end
        if ($urandom_range(0, 99) < 15) begin
            rate = RATE_W'($urandom_range(1, 64));
        end else begin
            rate = RATE_W'($urandom_range(1, 1023));
        end
        bps    = MOD_W'($urandom_range(1, 10));
        layers = LAY_W'($urandom_range(1, 8));
        if ($urandom_range(0, 99) < 10) begin
            bps = MOD_W'($urandom_range(11, 15));
        end
        if ($urandom_range(0, 99) < 10) begin
            layers = LAY_W'($urandom_range(9, 15));
        end
        // one request in about twenty gets a zero field
        case ($urandom_range(0, 79))
            0: re     = '0;
            1: rate   = '0;
            2: bps    = '0;
            3: layers = '0;
            default: ;
        endcase
        send_request(re, rate, bps, layers);
    endtask

    // receiver: random backpressure, plus one long hold-off so the pipe fills
    initial begin
        rsp_ch.ready = 1'b0;
        stall_done   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!stall_done && sent >= STALL_AT) begin
                rsp_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
                stall_done = 1'b1;
            end
            rsp_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 25);
        end
    end

    // watchdog on handshake activity
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= HANG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.re_count        = '0;
        req_ch.rate_x1024      = '0;
        req_ch.bits_per_symbol = '0;
        req_ch.layer_count     = '0;
        sent                   = 0;
        idle_on                = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes and saturation
        send_request(16'd65535, 10'd1023, 4'd10, 4'd8);
        send_request(16'd65535, 10'd1023, 4'd15, 4'd15);
        send_request(16'd65535, 10'd1023, 4'd15, 4'd8);
        send_request(16'd65535, 10'd1023, 4'd8, 4'd15);
        send_request(16'd1, 10'd1, 4'd1, 4'd1);
        // invalid allocations, each field zero in turn
        send_request(16'd0, 10'd512, 4'd2, 4'd2);
        send_request(16'd100, 10'd0, 4'd2, 4'd2);
        send_request(16'd100, 10'd512, 4'd0, 4'd2);
        send_request(16'd100, 10'd512, 4'd2, 4'd0);
        send_request(16'd0, 10'd0, 4'd0, 4'd0);
        // n_info at and just above the small branch limit
        send_request(16'd3824, 10'd512, 4'd2, 4'd1);
        send_request(16'd3825, 10'd512, 4'd2, 4'd1);
        // n_info around the 24-bit offset, then a larger one, in the small branch
        send_request(16'd25, 10'd512, 4'd2, 4'd1);
        send_request(16'd26, 10'd512, 4'd2, 4'd1);
        send_request(16'd12, 10'd1023, 4'd10, 4'd8);
        // around the base graph 1 size limit, high and low rate, then one large allocation
        send_request(16'd8440, 10'd512, 4'd2, 4'd1);
        send_request(16'd8448, 10'd512, 4'd2, 4'd1);
        send_request(16'd8440, 10'd256, 4'd4, 4'd1);
        send_request(16'd8440, 10'd257, 4'd4, 4'd1);
        send_request(16'd40000, 10'd300, 4'd6, 4'd4);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            send_random_request();
        end
        req_ch.valid <= 1'b0;

        // drain outstanding results, then wait DRAIN_CYCLES spare cycles
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
